FILE: src/sic_pkg.sv
`default_nettype none
package sic_pkg;

  // string tags carried on the input tuser
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_MERGED = 2'd2;

  // wavefront token handed from cell to cell, one table row per token
  typedef struct packed {
    logic       valid;
    logic       first;  // row zero of the table
    logic [7:0] b;      // character of the second string for this row
    logic       v;      // table bit of the left neighbor in this row
  } tok_t;

  // ascii lower to upper case, other bytes pass unchanged
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) r = c - 8'h20;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/sic_cell.sv
`default_nettype none
module sic_cell
  import sic_pkg::*;
#(
  parameter int COL   = 0,
  parameter int DEPTH = 17
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              a_we,
  input  wire  [7:0]       a_data,
  input  wire  [7:0]       c_char,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  output logic [DEPTH-1:0] col
);

  logic [7:0] a;
  logic       up;
  logic       v_calc;

  // one table cell: step from above (second string) or from the left (first string)
  assign v_calc = ((COL == 0) && tok_in.first)
                | (!tok_in.first && up && (tok_in.b == c_char))
                | ((COL != 0) && tok_in.v && (a == c_char));

  // token down the row, column history and stored first-string character
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.first <= tok_in.first;
    tok_out.b     <= tok_in.b;
    tok_out.v     <= v_calc;
    if (tok_in.valid) begin
      up  <= v_calc;
      col <= {col[DEPTH-2:0], v_calc};
    end
    if (a_we) begin
      a <= a_data;
    end
  end

endmodule
`default_nettype wire

FILE: src/string_interleave_check_top.sv
`default_nettype none
// channel   dir  tdata         tuser       tlast
// s_axis    in   ch[7:0]       kind[1:0]   last
// m_axis    out  out_char[7:0] is_merge    end_of_run
//
// loading takes one cycle per character request; s_axis_tready drops while a run is checked
// after the last merged character: a check state, the wavefront fill through the
// cell row, a corner state, the traceback, then one result per cycle unless m_axis stalls
// a run that fails the length checks goes from the check state to a single not-a-merge result
// rst is synchronous and clears counts, state and the output valid; no clearing pass
// m_axis stalls hold the output register; the next run loads while the last result waits
module string_interleave_check_top
  import sic_pkg::*;
#(
  parameter int MAX_LEN = 16
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // ch[7:0]
  input  wire  [1:0] s_axis_tuser,   // kind[1:0]
  input  wire        s_axis_tlast,
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char[7:0]
  output logic       m_axis_tuser,   // is_merge
  output logic       m_axis_tlast
);

  localparam int CAP_C = 2 * MAX_LEN;
  localparam int NCELL = MAX_LEN + 1;
  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int MW    = $clog2(CAP_C + 1);
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PW    = $clog2(CAP_C);
  localparam int TW    = $clog2(CAP_C + 2);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_CORNER = 3'd3;
  localparam logic [2:0] ST_TRACE  = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;
  localparam logic [2:0] ST_NONE   = 3'd6;

  logic [2:0]       state;
  logic [CW-1:0]    na;
  logic [CW-1:0]    nb;
  logic [MW-1:0]    nc;
  logic             ovf;
  logic [7:0]       b_mem [MAX_LEN];
  logic [7:0]       c_mem [CAP_C];
  logic [TW-1:0]    t;
  logic [CW-1:0]    ti;
  logic [CW-1:0]    tj;
  logic [CAP_C-1:0] from_a;
  logic [PW-1:0]    k;
  tok_t             tok0;
  logic [7:0]       c_bc;

  tok_t             tok  [NCELL+1];
  logic [NCELL-1:0] cols [NCELL];
  logic [NCELL-1:0] a_we;

  logic             acc;
  logic             ld_a;
  logic             out_free;
  logic             emit_go;
  logic             run_bad;
  logic             fill_tok;
  logic [AW-1:0]    fill_b_addr;
  logic [PW-1:0]    fill_c_addr;
  logic [TW-1:0]    t_m1;
  logic [MW-1:0]    pos_full;
  logic [PW-1:0]    pos;
  logic [AW-1:0]    tr_b_addr;
  logic [CW-1:0]    tr_row;
  logic [CW-1:0]    ti_m1;
  logic             step_b;
  logic             emit_last;

  assign s_axis_tready = (state == ST_LOAD);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign ld_a          = acc && (s_axis_tuser == KIND_FIRST) && (na < CW'(MAX_LEN));
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit_go       = ((state == ST_EMIT) || (state == ST_NONE)) && out_free;

  // length and capacity checks before the table fill
  assign run_bad = ovf || (na == '0) || (nb == '0) || ((MW'(na) + MW'(nb)) != nc);

  // fill sequencer addresses: row t reads the second string at t-1, broadcast merged at t-1
  assign t_m1        = t - TW'(1);
  assign fill_tok    = (t <= TW'(nb));
  assign fill_b_addr = (fill_tok && (t != '0)) ? t_m1[AW-1:0] : '0;
  assign fill_c_addr = (t != '0) ? t_m1[PW-1:0] : '0;

  // traceback step from cell (ti, tj)
  assign pos_full  = MW'(ti) + MW'(tj) - MW'(1);
  assign pos       = pos_full[PW-1:0];
  assign ti_m1     = ti - CW'(1);
  assign tr_b_addr = (ti != '0) ? ti_m1[AW-1:0] : '0;
  assign tr_row    = nb - ti + CW'(1);
  assign step_b    = (ti != '0) && cols[tj][tr_row] && (b_mem[tr_b_addr] == c_mem[pos]);
  assign emit_last = ((MW'(k) + MW'(1)) == nc);

  // row of table cells, one per table column, column zero standing for the empty first-string prefix
  assign tok[0] = tok0;
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    if (g == 0) begin : g_edge
      assign a_we[g] = 1'b0;
    end else begin : g_body
      assign a_we[g] = ld_a && (na == CW'(g - 1));
    end
    sic_cell #(
      .COL  (g),
      .DEPTH(NCELL)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .a_we   (a_we[g]),
      .a_data (s_axis_tdata),
      .c_char (c_bc),
      .tok_in (tok[g]),
      .tok_out(tok[g+1]),
      .col    (cols[g])
    );
  end

  // control: sequencer and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      na    <= '0;
      nb    <= '0;
      nc    <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (acc) begin
            case (s_axis_tuser)
              KIND_FIRST: begin
                if (na < CW'(MAX_LEN)) na <= na + CW'(1);
                else ovf <= 1'b1;
              end
              KIND_SECOND: begin
                if (nb < CW'(MAX_LEN)) nb <= nb + CW'(1);
                else ovf <= 1'b1;
              end
              KIND_MERGED: begin
                if (nc < MW'(CAP_C)) nc <= nc + MW'(1);
                else ovf <= 1'b1;
                if (s_axis_tlast) state <= ST_CHECK;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CHECK: begin
          state <= run_bad ? ST_NONE : ST_FILL;
        end
        ST_FILL: begin
          if (t == (TW'(nc) + TW'(1))) state <= ST_CORNER;
        end
        ST_CORNER: begin
          state <= cols[na][0] ? ST_TRACE : ST_NONE;
        end
        ST_TRACE: begin
          if ((ti == '0) && (tj == '0)) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (emit_last) begin
              na    <= '0;
              nb    <= '0;
              nc    <= '0;
              ovf   <= 1'b0;
              state <= ST_LOAD;
            end
          end
        end
        ST_NONE: begin
          if (out_free) begin
            na    <= '0;
            nb    <= '0;
            nc    <= '0;
            ovf   <= 1'b0;
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // output valid: set on a new result, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // payload: character stores, wavefront feed, traceback and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok0.valid <= 1'b0;
    end else begin
      tok0.valid <= (state == ST_FILL) && fill_tok;
    end
    if (acc && (s_axis_tuser == KIND_SECOND) && (nb < CW'(MAX_LEN))) begin
      b_mem[nb[AW-1:0]] <= s_axis_tdata;
    end
    if (acc && (s_axis_tuser == KIND_MERGED) && (nc < MW'(CAP_C))) begin
      c_mem[nc[PW-1:0]] <= s_axis_tdata;
    end
    case (state)
      ST_CHECK: begin
        t <= '0;
      end
      ST_FILL: begin
        tok0.first <= (t == '0);
        tok0.b     <= b_mem[fill_b_addr];
        tok0.v     <= 1'b0;
        c_bc       <= c_mem[fill_c_addr];
        t          <= t + TW'(1);
      end
      ST_CORNER: begin
        ti     <= nb;
        tj     <= na;
        from_a <= '0;
        k      <= '0;
      end
      ST_TRACE: begin
        if ((ti != '0) || (tj != '0)) begin
          if (step_b) begin
            ti <= ti - CW'(1);
          end else if (tj != '0) begin
            from_a[pos] <= 1'b1;
            tj          <= tj - CW'(1);
          end else begin
            ti <= ti - CW'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_axis_tdata <= from_a[k] ? to_upper(c_mem[k]) : c_mem[k];
          m_axis_tuser <= 1'b1;
          m_axis_tlast <= emit_last;
          k            <= k + PW'(1);
        end
      end
      ST_NONE: begin
        if (out_free) begin
          m_axis_tdata <= 8'h00;
          m_axis_tuser <= 1'b0;
          m_axis_tlast <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/sic_checker.sv
`default_nettype none
module sic_checker (
  input wire       clk,
  input wire       rst,
  input wire       s_axis_tready,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata,
  input wire       m_axis_tuser,
  input wire       m_axis_tlast
);

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a not-a-merge result is a single zero character that ends the run
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == 8'h00) && m_axis_tlast)
    else $error("bad not-a-merge result");

  // only a merge run has results before its final one
  a_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser)
    else $error("merge run broken off");

  // reset empties the output register
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a result still in the middle of a run blocks new requests
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken during a run");

endmodule

bind string_interleave_check_top sic_checker u_sic_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire
